/* hdl/lbve_pkg.sv */
package lbve_pkg;

  // One segment as it arrives on the input channel.
  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic        [30:0] thick_a;
    logic        [30:0] thick_b;
    logic        [31:0] color_a;
    logic        [31:0] color_b;
  } in_word_t;

  // One vertex or triangle record on the result channel.
  typedef struct packed {
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic        [31:0] vert_color;
    logic        [23:0] tri_i0;
    logic        [23:0] tri_i1;
    logic        [23:0] tri_i2;
    logic               last;
  } out_word_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_THSQ,
    OP_DROP,
    OP_SCALE,
    OP_CLR,
    OP_ACC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_SETT,
    OP_XM1,
    OP_XM2,
    OP_XEND,
    OP_OFFM,
    OP_OFFW,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
    logic       sel;
    logic       ep;
    logic [2:0] face;
    logic [2:0] slot;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic in_range;
    logic out_free;
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DROP,
    ST_SCALE,
    ST_NSQ,
    ST_SQRT,
    ST_DIV,
    ST_SEL,
    ST_CROSS,
    ST_OFF,
    ST_EMIT
  } state_t;

  // Frame vector selectors.
  localparam logic [1:0] VEC_DIR = 2'd0;
  localparam logic [1:0] VEC_ONE = 2'd1;
  localparam logic [1:0] VEC_TWO = 2'd2;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam logic [2:0] LAST_FACE = 3'd5;
  localparam logic [2:0] LAST_SLOT = 3'd5;

  // Squared-length limit at or below which dir x z replaces dir x x (0.01 in Q60).
  localparam logic [63:0] SEL_LIMIT = ((64'd1 << 60) - 64'd1) / 64'd100;

  // Round to nearest, halves away from zero, dropping 30 fraction bits.
  function automatic logic signed [37:0] rnd30(input logic signed [67:0] v);
    logic [67:0] mag;
    logic [67:0] m;
    begin
      mag = v[67] ? 68'(-v) : 68'(v);
      m = (mag + (68'd1 << 29)) >> 30;
      rnd30 = v[67] ? -$signed(38'(m)) : $signed(38'(m));
    end
  endfunction

  // Q30 frame component to a Q2.14 normal, optionally negated, clamped.
  function automatic logic signed [15:0] norm16(input logic signed [31:0] v, input logic neg);
    logic [32:0] mag;
    logic [32:0] m;
    logic [15:0] c;
    begin
      mag = v[31] ? 33'(-$signed({v[31], v})) : 33'({1'b0, v});
      m = (mag + 33'd32768) >> 16;
      c = (m > 33'd16384) ? 16'd16384 : m[15:0];
      norm16 = (v[31] ^ neg) ? -$signed(c) : $signed(c);
    end
  endfunction

  // Corner code {end_b, negate one, negate two}.
  function automatic logic [2:0] corner_code(input logic [2:0] face, input logic [1:0] k);
    logic [11:0] row;
    begin
      case (face)
        3'd0:    row = {3'b000, 3'b100, 3'b110, 3'b010};
        3'd1:    row = {3'b001, 3'b101, 3'b111, 3'b011};
        3'd2:    row = {3'b000, 3'b100, 3'b101, 3'b001};
        3'd3:    row = {3'b010, 3'b110, 3'b111, 3'b011};
        3'd4:    row = {3'b010, 3'b000, 3'b001, 3'b011};
        3'd5:    row = {3'b110, 3'b100, 3'b101, 3'b111};
        default: row = '0;
      endcase
      corner_code = row[3*k +: 3];
    end
  endfunction

  function automatic logic [1:0] face_vec(input logic [2:0] face);
    begin
      case (face)
        3'd0, 3'd1: face_vec = VEC_TWO;
        3'd2, 3'd3: face_vec = VEC_ONE;
        default:    face_vec = VEC_DIR;
      endcase
    end
  endfunction

  function automatic logic face_neg(input logic [2:0] face);
    begin
      case (face)
        3'd1, 3'd3, 3'd4: face_neg = 1'b1;
        default:          face_neg = 1'b0;
      endcase
    end
  endfunction

  function automatic logic face_fwd(input logic [2:0] face);
    begin
      case (face)
        3'd0, 3'd3, 3'd5: face_fwd = 1'b1;
        default:          face_fwd = 1'b0;
      endcase
    end
  endfunction

endpackage

/* hdl/lbve_in_if.sv */
interface lbve_in_if;
  import lbve_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* hdl/lbve_out_if.sv */
interface lbve_out_if;
  import lbve_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* hdl/line_to_box_vertex_expander_core.sv */
// Channel   Direction  Word        Handshake
// in_ch     input      in_word_t   valid/ready, one segment per word
// out_ch    output     out_word_t  valid/ready, 36 records per kept segment
//
// A segment runs through the length test, the scaling of the direction and two
// normalizations, each with a bit-serial square root and a one-bit-per-cycle divider,
// then the two cross products, the corner offsets and the emit step. Short segments
// leave after the length test.
// Synchronous active-low reset clears the sequencer, the vertex counter and out valid.
// A stalled output only holds the emit step; the next segment is taken once the
// last record sits in the output register.
module line_to_box_vertex_expander_core #(
  parameter int INDEX_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lbve_in_if.sink   in_ch,
  lbve_out_if.source out_ch
);
  import lbve_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lbve_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbve_dpath #(
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data)
  );

endmodule

/* hdl/lbve_ctrl.sv */
module lbve_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lbve_pkg::stat_t stat,
  output lbve_pkg::cmd_t  cmd
);
  import lbve_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       pass_r, pass_nxt;
  logic       ep_r, ep_nxt;
  logic [2:0] face_r, face_nxt;
  logic [2:0] slot_r, slot_nxt;

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      pass_r  <= 1'b0;
      ep_r    <= 1'b0;
      face_r  <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      pass_r  <= pass_nxt;
      ep_r    <= ep_nxt;
      face_r  <= face_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // Next state and counters.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    idx_nxt   = idx_r;
    pass_nxt  = pass_r;
    ep_nxt    = ep_r;
    face_nxt  = face_r;
    slot_nxt  = slot_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = ST_DROP;
          pass_nxt  = 1'b0;
          idx_nxt   = '0;
        end
      end
      ST_DROP: begin
        if (cnt_r == 6'd5) begin
          cnt_nxt   = '0;
          state_nxt = stat.drop ? ST_IDLE : ST_SCALE;
        end
      end
      ST_SCALE: begin
        cnt_nxt = '0;
        if (stat.in_range) begin
          state_nxt = ST_NSQ;
        end
      end
      ST_NSQ: begin
        if (cnt_r == 6'd4) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_r == 6'(SQRT_STEPS)) begin
          cnt_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == 6'(DIV_STEPS + 1)) begin
          cnt_nxt = '0;
          if (idx_r == 2'd2) begin
            idx_nxt = '0;
            if (pass_r) begin
              pass_nxt  = 1'b0;
              state_nxt = ST_CROSS;
            end else begin
              state_nxt = ST_SEL;
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ST_SEL: begin
        if (cnt_r == 6'd4) begin
          cnt_nxt   = '0;
          pass_nxt  = 1'b1;
          state_nxt = ST_NSQ;
        end
      end
      ST_CROSS: begin
        if (cnt_r == 6'd2) begin
          cnt_nxt = '0;
          if (idx_r == 2'd2) begin
            idx_nxt = '0;
            if (pass_r) begin
              pass_nxt  = 1'b0;
              ep_nxt    = 1'b0;
              state_nxt = ST_OFF;
            end else begin
              pass_nxt = 1'b1;
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ST_OFF: begin
        if (cnt_r[0]) begin
          cnt_nxt = '0;
          if (idx_r == 2'd2) begin
            idx_nxt = '0;
            if (pass_r) begin
              pass_nxt = 1'b0;
              if (ep_r) begin
                ep_nxt    = 1'b0;
                face_nxt  = '0;
                slot_nxt  = '0;
                state_nxt = ST_EMIT;
              end else begin
                ep_nxt = 1'b1;
              end
            end else begin
              pass_nxt = 1'b1;
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ST_EMIT: begin
        cnt_nxt = '0;
        if (stat.out_free) begin
          if (slot_r == LAST_SLOT) begin
            slot_nxt = '0;
            if (face_r == LAST_FACE) begin
              face_nxt  = '0;
              state_nxt = ST_IDLE;
            end else begin
              face_nxt = face_r + 3'd1;
            end
          end else begin
            slot_nxt = slot_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Command decode.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '{op: OP_NONE, idx: idx_r, sel: pass_r, ep: ep_r, face: face_r, slot: slot_r};
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_DROP: begin
        cmd.sel = 1'b0;
        cmd.idx = cnt_r[1:0];
        case (cnt_r)
          6'd0, 6'd1, 6'd2: cmd.op = OP_SQ;
          6'd3:             cmd.op = OP_THSQ;
          6'd4:             cmd.op = OP_DROP;
          default:          cmd.op = OP_NONE;
        endcase
      end
      ST_SCALE: begin
        if (!stat.in_range) cmd.op = OP_SCALE;
      end
      ST_NSQ: begin
        cmd.sel = 1'b0;
        cmd.idx = 2'(cnt_r - 6'd1);
        case (cnt_r)
          6'd0:             cmd.op = OP_CLR;
          6'd1, 6'd2, 6'd3: cmd.op = OP_SQ;
          6'd4:             cmd.op = OP_ACC;
          default:          cmd.op = OP_NONE;
        endcase
      end
      ST_SQRT: begin
        cmd.op = (cnt_r == '0) ? OP_SQRT_INIT : OP_SQRT_STEP;
      end
      ST_DIV: begin
        if (cnt_r == '0) cmd.op = OP_DIV_INIT;
        else if (cnt_r == 6'(DIV_STEPS + 1)) cmd.op = OP_DIV_END;
        else cmd.op = OP_DIV_STEP;
      end
      ST_SEL: begin
        cmd.sel = 1'b1;
        cmd.idx = cnt_r[1:0];
        case (cnt_r)
          6'd0:       cmd.op = OP_CLR;
          6'd1, 6'd2: cmd.op = OP_SQ;
          6'd3:       cmd.op = OP_ACC;
          6'd4:       cmd.op = OP_SETT;
          default:    cmd.op = OP_NONE;
        endcase
      end
      ST_CROSS: begin
        case (cnt_r)
          6'd0:    cmd.op = OP_XM1;
          6'd1:    cmd.op = OP_XM2;
          default: cmd.op = OP_XEND;
        endcase
      end
      ST_OFF: begin
        cmd.op = cnt_r[0] ? OP_OFFW : OP_OFFM;
      end
      ST_EMIT: begin
        if (stat.out_free) cmd.op = OP_EMIT;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

/* hdl/lbve_dpath.sv */
module lbve_dpath #(
  parameter int INDEX_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lbve_pkg::in_word_t  in_data,
  input  lbve_pkg::cmd_t      cmd,
  output lbve_pkg::stat_t     stat,
  input  logic                out_ready,
  output logic                out_valid,
  output lbve_pkg::out_word_t out_data
);
  import lbve_pkg::*;

  // Thickness floor of 1e-7 in LSBs, at least one.
  localparam int FLO_RAW = ((1 << FRAC_BITS) + 5000000) / 10000000;
  localparam int FLO     = (FLO_RAW < 1) ? 1 : FLO_RAW;

  logic signed [31:0] pa_r [3];
  logic signed [31:0] pb_r [3];
  logic        [30:0] tha_r, thb_r;
  logic        [31:0] ca_r, cb_r;
  logic        [32:0] dm_r [3];
  logic               sgn_r [3];
  logic        [32:0] maxm_r;
  logic signed [67:0] acc_r;
  logic signed [65:0] prod_r;
  logic               drop_r;
  logic        [63:0] sv_r, sr_r, sb_r;
  logic        [31:0] den_r, rem_r, qn_r;
  logic signed [31:0] dir_r [3];
  logic signed [31:0] tmp_r [3];
  logic signed [31:0] one_r [3];
  logic signed [31:0] two_r [3];
  logic signed [35:0] off_r [2][2][3];
  logic [INDEX_BITS-1:0] vc_r;
  logic               out_valid_r;
  out_word_t          out_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_nxt;
  logic        [30:0] th_min;
  logic signed [32:0] d_ld [3];
  logic        [32:0] dm_ld [3];
  logic        [32:0] maxm_ld;
  logic        [1:0]  xa, xb;
  logic        [79:0] l2x;
  logic        [63:0] sq_sum;
  logic        [32:0] div_t;
  logic        [31:0] den_ld;
  logic        [63:0] num_ld;
  logic signed [31:0] div_q;
  logic signed [67:0] xdiff;
  logic               out_free;
  out_word_t          out_nxt;

  // Segment difference and its magnitudes at load.
  always_comb begin
    maxm_ld = '0;
    for (int i = 0; i < 3; i++) begin
      d_ld[i]  = 33'(in_data.b_x) - 33'(in_data.a_x);
      dm_ld[i] = '0;
    end
    d_ld[0] = $signed({in_data.b_x[31], in_data.b_x}) - $signed({in_data.a_x[31], in_data.a_x});
    d_ld[1] = $signed({in_data.b_y[31], in_data.b_y}) - $signed({in_data.a_y[31], in_data.a_y});
    d_ld[2] = $signed({in_data.b_z[31], in_data.b_z}) - $signed({in_data.a_z[31], in_data.a_z});
    for (int i = 0; i < 3; i++) begin
      dm_ld[i] = d_ld[i][32] ? 33'(-d_ld[i]) : 33'(d_ld[i]);
      if (dm_ld[i] > maxm_ld) maxm_ld = dm_ld[i];
    end
  end

  // Smaller thickness, held at the floor.
  always_comb begin
    th_min = (tha_r < thb_r) ? tha_r : thb_r;
    if (th_min < 31'(FLO)) th_min = 31'(FLO);
  end

  // Cross product operand rotation.
  always_comb begin
    case (cmd.idx)
      2'd0:    begin xa = 2'd1; xb = 2'd2; end
      2'd1:    begin xa = 2'd2; xb = 2'd0; end
      default: begin xa = 2'd0; xb = 2'd1; end
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ: begin
        if (cmd.sel) begin
          mul_a = 33'(dir_r[cmd.idx]);
        end else begin
          mul_a = $signed({1'b0, dm_r[cmd.idx][31:0]});
        end
        mul_b = mul_a;
      end
      OP_THSQ: begin
        mul_a = $signed({2'b00, th_min});
        mul_b = mul_a;
      end
      OP_XM1: begin
        mul_a = 33'(dir_r[xa]);
        mul_b = cmd.sel ? 33'(one_r[xb]) : 33'(tmp_r[xb]);
      end
      OP_XM2: begin
        mul_a = 33'(dir_r[xb]);
        mul_b = cmd.sel ? 33'(one_r[xa]) : 33'(tmp_r[xa]);
      end
      OP_OFFM: begin
        mul_a = $signed({2'b00, cmd.ep ? thb_r : tha_r});
        mul_b = cmd.sel ? 33'(two_r[cmd.idx]) : 33'(one_r[cmd.idx]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Drop test: 10000 * squared length against squared thickness.
  always_comb begin
    l2x = ({16'd0, acc_r[63:0]} << 13) + ({16'd0, acc_r[63:0]} << 10)
        + ({16'd0, acc_r[63:0]} << 9) + ({16'd0, acc_r[63:0]} << 8)
        + ({16'd0, acc_r[63:0]} << 4);
  end

  // Square root and divider step helpers.
  always_comb begin
    sq_sum = sr_r + sb_r;
    div_t  = {rem_r, qn_r[31]};
    den_ld = (sr_r[31:0] == '0) ? 32'd1 : sr_r[31:0];
    num_ld = {2'b00, dm_r[cmd.idx][31:0], 30'd0} + {33'd0, den_ld[31:1]};
    div_q  = sgn_r[cmd.idx] ? -$signed(qn_r) : $signed(qn_r);
    xdiff  = acc_r - 68'(prod_r);
  end

  // Record assembly for the current face and slot.
  always_comb begin
    logic [2:0]         cc;
    logic               eb;
    logic signed [37:0] sum;
    logic signed [35:0] t1, t2;
    logic signed [31:0] pv, nv;
    logic [1:0]         fv;
    logic [INDEX_BITS-1:0] base;
    logic [1:0]         j1, j2;
    out_nxt = '0;
    cc = corner_code(cmd.face, cmd.slot[1:0]);
    eb = cc[2];
    fv = face_vec(cmd.face);
    base = vc_r + INDEX_BITS'({cmd.face, 2'b00});
    if (face_fwd(cmd.face)) begin
      j1 = 2'd1 + {1'b0, cmd.slot[0]};
      j2 = 2'd2 + {1'b0, cmd.slot[0]};
    end else begin
      j1 = 2'd2 + {1'b0, cmd.slot[0]};
      j2 = 2'd1 + {1'b0, cmd.slot[0]};
    end
    if (cmd.slot[2]) begin
      out_nxt.kind   = 1'b1;
      out_nxt.tri_i0 = 24'(base);
      out_nxt.tri_i1 = 24'(base + INDEX_BITS'(j1));
      out_nxt.tri_i2 = 24'(base + INDEX_BITS'(j2));
    end else begin
      out_nxt.vert_color = eb ? cb_r : ca_r;
      for (int i = 0; i < 3; i++) begin
        pv = eb ? pb_r[i] : pa_r[i];
        t1 = off_r[eb][0][i];
        t2 = off_r[eb][1][i];
        sum = 38'(pv) + (cc[1] ? -38'(t1) : 38'(t1)) + (cc[0] ? -38'(t2) : 38'(t2));
        if (sum > 38'sd2147483647) pv = 32'sh7fffffff;
        else if (sum < -38'sd2147483648) pv = 32'sh80000000;
        else pv = 32'(sum);
        case (fv)
          VEC_ONE: nv = one_r[i];
          VEC_TWO: nv = two_r[i];
          default: nv = dir_r[i];
        endcase
        case (i)
          0: begin
            out_nxt.pos_x  = pv;
            out_nxt.norm_x = norm16(nv, face_neg(cmd.face));
          end
          1: begin
            out_nxt.pos_y  = pv;
            out_nxt.norm_y = norm16(nv, face_neg(cmd.face));
          end
          default: begin
            out_nxt.pos_z  = pv;
            out_nxt.norm_z = norm16(nv, face_neg(cmd.face));
          end
        endcase
      end
    end
    out_nxt.last = (cmd.face == LAST_FACE) && (cmd.slot == LAST_SLOT);
  end

  assign out_free = !out_valid_r || out_ready;

  // Control state: output valid, vertex counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vc_r        <= '0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
        if (out_nxt.last) vc_r <= vc_r + INDEX_BITS'(24);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the frame computation.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        pa_r[0] <= in_data.a_x; pa_r[1] <= in_data.a_y; pa_r[2] <= in_data.a_z;
        pb_r[0] <= in_data.b_x; pb_r[1] <= in_data.b_y; pb_r[2] <= in_data.b_z;
        tha_r  <= in_data.thick_a;
        thb_r  <= in_data.thick_b;
        ca_r   <= in_data.color_a;
        cb_r   <= in_data.color_b;
        maxm_r <= maxm_ld;
        for (int i = 0; i < 3; i++) begin
          dm_r[i]  <= dm_ld[i];
          sgn_r[i] <= d_ld[i][32];
        end
        acc_r  <= '0;
        prod_r <= '0;
      end
      OP_SQ, OP_THSQ: begin
        acc_r  <= acc_r + 68'(prod_r);
        prod_r <= prod_nxt;
      end
      OP_DROP: begin
        drop_r <= (maxm_r < (33'd1 << 26)) && (l2x < {16'd0, prod_r[63:0]});
      end
      OP_SCALE: begin
        if (maxm_r[32:31] != 2'b00) begin
          maxm_r <= maxm_r >> 1;
          for (int i = 0; i < 3; i++) dm_r[i] <= dm_r[i] >> 1;
        end else begin
          maxm_r <= maxm_r << 1;
          for (int i = 0; i < 3; i++) dm_r[i] <= dm_r[i] << 1;
        end
      end
      OP_CLR: begin
        acc_r  <= '0;
        prod_r <= '0;
      end
      OP_ACC: begin
        acc_r  <= acc_r + 68'(prod_r);
        prod_r <= '0;
      end
      OP_SQRT_INIT: begin
        sv_r <= acc_r[63:0];
        sr_r <= '0;
        sb_r <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sv_r >= sq_sum) begin
          sv_r <= sv_r - sq_sum;
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
      end
      OP_DIV_INIT: begin
        den_r <= den_ld;
        rem_r <= num_ld[63:32];
        qn_r  <= num_ld[31:0];
      end
      OP_DIV_STEP: begin
        if (div_t >= {1'b0, den_r}) begin
          rem_r <= 32'(div_t - {1'b0, den_r});
          qn_r  <= {qn_r[30:0], 1'b1};
        end else begin
          rem_r <= div_t[31:0];
          qn_r  <= {qn_r[30:0], 1'b0};
        end
      end
      OP_DIV_END: begin
        if (cmd.sel) tmp_r[cmd.idx] <= div_q;
        else dir_r[cmd.idx] <= div_q;
      end
      OP_SETT: begin
        if (acc_r[63:0] <= SEL_LIMIT) begin
          dm_r[0]  <= dir_r[1][31] ? 33'(-33'(dir_r[1])) : 33'(dir_r[1]);
          sgn_r[0] <= dir_r[1][31];
          dm_r[1]  <= dir_r[0][31] ? 33'(-33'(dir_r[0])) : 33'(dir_r[0]);
          sgn_r[1] <= !dir_r[0][31];
          dm_r[2]  <= '0;
          sgn_r[2] <= 1'b0;
        end else begin
          dm_r[0]  <= '0;
          sgn_r[0] <= 1'b0;
          dm_r[1]  <= dir_r[2][31] ? 33'(-33'(dir_r[2])) : 33'(dir_r[2]);
          sgn_r[1] <= dir_r[2][31];
          dm_r[2]  <= dir_r[1][31] ? 33'(-33'(dir_r[1])) : 33'(dir_r[1]);
          sgn_r[2] <= !dir_r[1][31];
        end
      end
      OP_XM1: begin
        prod_r <= prod_nxt;
      end
      OP_XM2: begin
        acc_r  <= 68'(prod_r);
        prod_r <= prod_nxt;
      end
      OP_XEND: begin
        if (cmd.sel) two_r[cmd.idx] <= 32'(rnd30(xdiff));
        else one_r[cmd.idx] <= 32'(rnd30(xdiff));
      end
      OP_OFFM: begin
        prod_r <= prod_nxt;
      end
      OP_OFFW: begin
        off_r[cmd.ep][cmd.sel][cmd.idx] <= 36'(rnd30(68'(prod_r)));
      end
      OP_EMIT: begin
        out_r <= out_nxt;
      end
      default: begin
      end
    endcase
  end

  assign stat.drop     = drop_r;
  assign stat.in_range = (maxm_r[32:31] == 2'b00) && maxm_r[30];
  assign stat.out_free = out_free;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import lbve_pkg::*;

  typedef longint vec3_t [3];

  localparam int IDX_W     = 24;
  localparam int FRAC_W    = 16;
  localparam int Q_BITS    = 30;
  localparam int N_RANDOM  = 150;
  localparam int STALL_MAX = 20000;

  // Codes that pick the frame vector of a face normal.
  localparam int FRAME_DIR = 0;
  localparam int FRAME_ONE = 1;
  localparam int FRAME_TWO = 2;

  logic clk;
  logic rst_n;

  lbve_in_if  seg_ch();
  lbve_out_if rec_ch();

  line_to_box_vertex_expander_core #(
    .INDEX_BITS(IDX_W),
    .FRAC_BITS (FRAC_W)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (seg_ch.sink),
    .out_ch(rec_ch.source)
  );

  in_word_t    seg_pending[$];
  out_word_t   rec_expected[$];
  logic [23:0] box_base;
  int          n_errors;
  int          cyc;
  int          quiet_cycles;

  // Round to nearest, halves away from zero, dropping n fraction bits.
  function automatic longint round_shift(input longint v, input int n);
    longint unsigned m;
    begin
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + (64'd1 << (n - 1))) >> n;
      round_shift = (v < 0) ? -longint'(m) : longint'(m);
    end
  endfunction

  // Floor integer square root, bit by bit.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    begin
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      floor_sqrt = r;
    end
  endfunction

  // Scale a vector to unit length in Q30.
  function automatic vec3_t unit_q30(input vec3_t v);
    longint unsigned m[3];
    longint unsigned s;
    longint unsigned len;
    longint unsigned q;
    vec3_t r;
    begin
      s = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
        s = s + m[i] * m[i];
      end
      len = floor_sqrt(s);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << Q_BITS) + len / 2) / len;
        r[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      unit_q30 = r;
    end
  endfunction

  function automatic vec3_t cross_q30(input vec3_t p, input vec3_t q);
    vec3_t r;
    begin
      r[0] = round_shift(p[1] * q[2] - p[2] * q[1], Q_BITS);
      r[1] = round_shift(p[2] * q[0] - p[0] * q[2], Q_BITS);
      r[2] = round_shift(p[0] * q[1] - p[1] * q[0], Q_BITS);
      cross_q30 = r;
    end
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    begin
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      clamp32 = v[31:0];
    end
  endfunction

  function automatic logic signed [15:0] normal_q14(input longint v, input logic flip);
    longint n;
    begin
      n = round_shift(v, Q_BITS - 14);
      if (flip) n = -n;
      if (n > 16384) n = 16384;
      if (n < -16384) n = -16384;
      normal_q14 = n[15:0];
    end
  endfunction

  // Corner of a face: {at end b, negate one, negate two}.
  function automatic logic [2:0] box_corner(input int face, input int k);
    logic [11:0] row;
    begin
      case (face)
        0:       row = {3'b010, 3'b110, 3'b100, 3'b000};
        1:       row = {3'b011, 3'b111, 3'b101, 3'b001};
        2:       row = {3'b001, 3'b101, 3'b100, 3'b000};
        3:       row = {3'b011, 3'b111, 3'b110, 3'b010};
        4:       row = {3'b011, 3'b001, 3'b000, 3'b010};
        default: row = {3'b111, 3'b101, 3'b100, 3'b110};
      endcase
      box_corner = row[11 - 3 * k -: 3];
    end
  endfunction

  // Work out the records of one segment and queue them.
  task automatic expand_segment(input in_word_t w);
    vec3_t pa, pb, d, dir, t, tmp, one, two;
    longint unsigned dm[3];
    longint unsigned maxm, tha, thb, thmin, flo, l2, s;
    longint th, t1, t2;
    logic [2:0] cc;
    logic [23:0] base;
    int fv, n, j1, j2;
    logic flip, fwd;
    out_word_t r;
    begin
      pa[0] = w.a_x; pa[1] = w.a_y; pa[2] = w.a_z;
      pb[0] = w.b_x; pb[1] = w.b_y; pb[2] = w.b_z;
      tha = w.thick_a;
      thb = w.thick_b;
      maxm = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = pb[i] - pa[i];
        dm[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
        if (dm[i] > maxm) maxm = dm[i];
      end

      // Short segments vanish; the thickness floor makes zero length always vanish.
      flo = ((64'd1 << FRAC_W) + 64'd5000000) / 64'd10000000;
      if (flo < 1) flo = 1;
      thmin = (tha < thb) ? tha : thb;
      if (thmin < flo) thmin = flo;
      if (maxm < (64'd1 << 26)) begin
        l2 = dm[0] * dm[0] + dm[1] * dm[1] + dm[2] * dm[2];
        if (l2 <= (thmin * thmin - 1) / 10000) return;
      end

      // Bring the largest magnitude into [2^30, 2^31).
      while (maxm >= (64'd1 << 31)) begin
        for (int i = 0; i < 3; i++) dm[i] = dm[i] >> 1;
        maxm = maxm >> 1;
      end
      while (maxm < (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) dm[i] = dm[i] << 1;
        maxm = maxm << 1;
      end
      for (int i = 0; i < 3; i++) d[i] = (d[i] < 0) ? -longint'(dm[i]) : longint'(dm[i]);
      dir = unit_q30(d);

      // Near the x axis the helper vector comes from z instead of x.
      s = longint'(dir[1] * dir[1]) + longint'(dir[2] * dir[2]);
      if (s <= ((64'd1 << 60) - 1) / 100) begin
        t[0] = dir[1]; t[1] = -dir[0]; t[2] = 0;
      end else begin
        t[0] = 0; t[1] = dir[2]; t[2] = -dir[1];
      end
      tmp = unit_q30(t);
      one = cross_q30(dir, tmp);
      two = cross_q30(dir, one);

      n = 0;
      for (int f = 0; f < 6; f++) begin
        fv = (f < 2) ? FRAME_TWO : (f < 4) ? FRAME_ONE : FRAME_DIR;
        flip = (f == 1) || (f == 3) || (f == 4);
        fwd = (f == 0) || (f == 3) || (f == 5);
        base = box_base + 24'(4 * f);
        for (int k = 0; k < 4; k++) begin
          cc = box_corner(f, k);
          th = cc[2] ? longint'(thb) : longint'(tha);
          r = '0;
          for (int i = 0; i < 3; i++) begin
            t1 = round_shift(th * one[i], Q_BITS);
            t2 = round_shift(th * two[i], Q_BITS);
            if (cc[1]) t1 = -t1;
            if (cc[0]) t2 = -t2;
            case (i)
              0: r.pos_x = clamp32((cc[2] ? pb[0] : pa[0]) + t1 + t2);
              1: r.pos_y = clamp32((cc[2] ? pb[1] : pa[1]) + t1 + t2);
              default: r.pos_z = clamp32((cc[2] ? pb[2] : pa[2]) + t1 + t2);
            endcase
          end
          case (fv)
            FRAME_TWO: begin
              r.norm_x = normal_q14(two[0], flip);
              r.norm_y = normal_q14(two[1], flip);
              r.norm_z = normal_q14(two[2], flip);
            end
            FRAME_ONE: begin
              r.norm_x = normal_q14(one[0], flip);
              r.norm_y = normal_q14(one[1], flip);
              r.norm_z = normal_q14(one[2], flip);
            end
            default: begin
              r.norm_x = normal_q14(dir[0], flip);
              r.norm_y = normal_q14(dir[1], flip);
              r.norm_z = normal_q14(dir[2], flip);
            end
          endcase
          r.vert_color = cc[2] ? w.color_b : w.color_a;
          rec_expected.push_back(r);
          n++;
        end
        for (int k = 0; k < 2; k++) begin
          j1 = fwd ? 1 + k : 2 + k;
          j2 = fwd ? 2 + k : 1 + k;
          r = '0;
          r.kind = 1'b1;
          r.tri_i0 = base;
          r.tri_i1 = base + 24'(j1);
          r.tri_i2 = base + 24'(j2);
          r.last = (n == 35);
          rec_expected.push_back(r);
          n++;
        end
      end
      box_base = box_base + 24'd24;
    end
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    begin
      if (want !== got) begin
        $display("%0t: field %s expected %h actual %h", $time, name, want, got);
        n_errors++;
      end
    end
  endtask

  task automatic check_record(input out_word_t got);
    out_word_t want;
    begin
      if (rec_expected.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, got);
        n_errors++;
      end else begin
        want = rec_expected.pop_front();
        report_field("kind", want.kind, got.kind);
        report_field("pos_x", want.pos_x, got.pos_x);
        report_field("pos_y", want.pos_y, got.pos_y);
        report_field("pos_z", want.pos_z, got.pos_z);
        report_field("norm_x", want.norm_x, got.norm_x);
        report_field("norm_y", want.norm_y, got.norm_y);
        report_field("norm_z", want.norm_z, got.norm_z);
        report_field("vert_color", want.vert_color, got.vert_color);
        report_field("tri_i0", want.tri_i0, got.tri_i0);
        report_field("tri_i1", want.tri_i1, got.tri_i1);
        report_field("tri_i2", want.tri_i2, got.tri_i2);
        report_field("last", want.last, got.last);
      end
    end
  endtask

  function automatic in_word_t make_seg(input int ax, input int ay, input int az,
                                        input int bx, input int by, input int bz,
                                        input int ta, input int tb_th,
                                        input logic [31:0] ca, input logic [31:0] cb);
    in_word_t w;
    begin
      w.a_x = ax; w.a_y = ay; w.a_z = az;
      w.b_x = bx; w.b_y = by; w.b_z = bz;
      w.thick_a = ta[30:0]; w.thick_b = tb_th[30:0];
      w.color_a = ca; w.color_b = cb;
      make_seg = w;
    end
  endfunction

  function automatic int spread(input int r);
    begin
      spread = int'($urandom_range(0, 2 * r)) - r;
    end
  endfunction

  // Random segments: mostly well-formed ones, some near the drop limit or an axis.
  function automatic in_word_t random_seg();
    in_word_t w;
    int ax, ay, az, r;
    begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
      ax = $urandom; ay = $urandom; az = $urandom;
      case ($urandom_range(0, 5))
        0: ;
        1: begin
          // Length of the order of the thickness, so some are dropped.
          w.thick_a = 31'($urandom_range(0, 1 << 20));
          w.thick_b = 31'($urandom_range(0, 1 << 20));
          r = 1 << $urandom_range(0, 14);
          w.b_x = w.a_x + spread(r); w.b_y = w.a_y + spread(r); w.b_z = w.a_z + spread(r);
        end
        2: begin
          // Almost along x, which takes the z helper.
          ax = ax >>> 2; ay = ay >>> 2; az = az >>> 2;
          w.a_x = ax; w.a_y = ay; w.a_z = az;
          r = 1 << $urandom_range(4, 28);
          w.b_x = ax + ((r >> 1) + int'($urandom_range(0, r >> 1)));
          w.b_y = ay + spread(r >> 5);
          w.b_z = az + spread(r >> 5);
          w.thick_a = 31'($urandom_range(0, 1 << 22));
          w.thick_b = 31'($urandom_range(0, 1 << 22));
        end
        default: begin
          ax = ax >>> 4; ay = ay >>> 4; az = az >>> 4;
          r = 1 << $urandom_range(8, 26);
          w.a_x = ax; w.a_y = ay; w.a_z = az;
          w.b_x = ax + spread(r); w.b_y = ay + spread(r); w.b_z = az + spread(r);
          w.thick_a = 31'($urandom_range(0, 1 << $urandom_range(0, 24)));
          w.thick_b = 31'($urandom_range(0, 1 << $urandom_range(0, 24)));
        end
      endcase
      random_seg = w;
    end
  endfunction

  // Stretches without idling now and then.
  function automatic logic take_break();
    begin
      take_break = ((cyc % 30000) >= 8000) && ($urandom_range(0, 99) < 14);
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Segment driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      seg_ch.valid <= 1'b0;
      seg_ch.data <= '0;
    end else if (!seg_ch.valid || seg_ch.ready) begin
      if (seg_pending.size() != 0 && !take_break()) begin
        seg_ch.data <= seg_pending.pop_front();
        seg_ch.valid <= 1'b1;
      end else begin
        seg_ch.valid <= 1'b0;
      end
    end
  end

  // Record sink readiness.
  always @(posedge clk) begin
    if (!rst_n) begin
      rec_ch.ready <= 1'b0;
    end else begin
      rec_ch.ready <= !take_break();
    end
  end

  // Monitor: checks records, predicts accepted segments, and watches for a hang.
  always @(posedge clk) begin
    if (!rst_n) begin
      box_base <= '0;
      quiet_cycles <= 0;
    end else begin
      cyc <= cyc + 1;
      if (rec_ch.valid && rec_ch.ready) check_record(rec_ch.data);
      if (seg_ch.valid && seg_ch.ready) expand_segment(seg_ch.data);
      if ((rec_ch.valid && rec_ch.ready) || (seg_ch.valid && seg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    n_errors = 0;
    cyc = 0;
    box_base = '0;
    rst_n = 1'b0;
    seg_ch.valid = 1'b0;
    seg_ch.data = '0;
    rec_ch.ready = 1'b0;

    // Directed segments: drops, axis directions, extremes, saturation.
    seg_pending.push_back(make_seg(0, 0, 0, 0, 0, 0, 0, 0, 32'h0, 32'hFFFF_FFFF));
    seg_pending.push_back(make_seg(5, 5, 5, 5, 5, 5, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h1234_5678, 32'h8765_4321));
    seg_pending.push_back(make_seg(0, 0, 0, 1, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0));
    seg_pending.push_back(make_seg(0, 0, 0, 100, 0, 0, 1 << 16, 1 << 16,
                                   32'hAAAA_AAAA, 32'h5555_5555));
    seg_pending.push_back(make_seg(0, 0, 0, 65536, 0, 0, 65536, 65536,
                                   32'hFF00_00FF, 32'h00FF_FF00));
    seg_pending.push_back(make_seg(0, 0, 0, 0, 65536, 0, 65536, 32768,
                                   32'h0102_0304, 32'h0506_0708));
    seg_pending.push_back(make_seg(0, 0, 0, 0, 0, 65536, 1, 2, 32'h1, 32'h2));
    seg_pending.push_back(make_seg(0, 0, 0, -65536, 0, 0, 65536, 65536, 32'h3, 32'h4));
    seg_pending.push_back(make_seg(0, 0, 0, 65536, 65536, 65536, 65536, 65536,
                                   32'h5, 32'h6));
    seg_pending.push_back(make_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    seg_pending.push_back(make_seg(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0,
                                   32'h7FFF_FFFF, 0, 32'h0, 32'hFFFF_FFFF));
    seg_pending.push_back(make_seg(32'h7FFF_FF00, 32'h7FFF_FF00, 0,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h100, 1 << 24, 1 << 24,
                                   32'hDEAD_BEEF, 32'hCAFE_F00D));
    seg_pending.push_back(make_seg(0, 0, 0, 1 << 20, 1 << 13, 0, 1 << 16, 1 << 16,
                                   32'h7, 32'h8));
    seg_pending.push_back(make_seg(0, 0, 0, 1 << 20, 1 << 18, 0, 1 << 16, 1 << 16,
                                   32'h9, 32'hA));
    seg_pending.push_back(make_seg(0, 0, 0, 1 << 10, 0, 0, 1 << 16, 1 << 16,
                                   32'hB, 32'hC));
    seg_pending.push_back(make_seg(0, 0, 0, 1 << 11, 0, 0, 1 << 18, 1 << 16,
                                   32'hD, 32'hE));
    seg_pending.push_back(make_seg(-1000, 2000, -3000, 1000, -2000, 3000, 0, 1 << 20,
                                   32'hF, 32'h10));
    for (int i = 0; i < N_RANDOM; i++) seg_pending.push_back(random_seg());

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (seg_pending.size() == 0 && !seg_ch.valid);
    wait (rec_expected.size() == 0);
    repeat (600) @(posedge clk);
    if (n_errors == 0 && rec_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
